/* rtl/ckps_pkg.sv */
// shared types and constants for the color key pixel select block
package ckps_pkg;

	localparam int CHAN_W          = 8;
	localparam int COLOR_W         = 3 * CHAN_W;
	localparam int ENTRY_W         = 2 * COLOR_W + 2;
	localparam int ENTRY_SLOTS     = 4;
	localparam int BLOCKED_ENTRIES = 4;
	localparam int EIDX_W          = $clog2(ENTRY_SLOTS);
	localparam int CFG_IDX_W       = 3;

	// blocked entry layout
	localparam int ENT_LO_LSB  = 0;
	localparam int ENT_HI_LSB  = COLOR_W;
	localparam int ENT_SPILL   = 2 * COLOR_W;
	localparam int ENT_VALID   = 2 * COLOR_W + 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_BELOW = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_ABOVE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GRAY_COLOR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKED_0   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKED_1   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKED_2   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKED_3   = 3'd7;

	// register reset values
	localparam logic [COLOR_W-1:0] KEY_COLOR_RST   = 24'h000000;
	localparam logic [COLOR_W-1:0] RANGE_BELOW_RST = 24'h282828;
	localparam logic [COLOR_W-1:0] RANGE_ABOVE_RST = 24'h282828;
	localparam logic [COLOR_W-1:0] GRAY_COLOR_RST  = 24'h646464;

	typedef enum logic [1:0] {
		SRC_ORIG = 2'd0,
		SRC_FILT = 2'd1,
		SRC_GRAY = 2'd2
	} src_t;

	typedef struct packed {
		logic [CHAN_W-1:0] filt_r;
		logic [CHAN_W-1:0] filt_g;
		logic [CHAN_W-1:0] filt_b;
		logic [CHAN_W-1:0] orig_r;
		logic [CHAN_W-1:0] orig_g;
		logic [CHAN_W-1:0] orig_b;
	} pix_t;

	typedef struct packed {
		logic [1:0]        chosen_source;
		logic [CHAN_W-1:0] out_r;
		logic [CHAN_W-1:0] out_g;
		logic [CHAN_W-1:0] out_b;
	} res_t;

endpackage

/* rtl/color_key_pixel_select_unit.sv */
// color key pixel select: chroma key with range tolerance and blocked ranges
// an accepted pixel passes the compare, select and result registers before it shows on res
// throughput: one pixel per cycle while res is not stalled, the three register stages all advance together
// a stalled result holds the whole pipeline, nothing is dropped or repeated
// reset (arst_n low, asynchronous) empties the pipeline and loads register defaults
// configuration writes complete in the cycle they are offered
module color_key_pixel_select_unit
	import ckps_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// pixel channel
	input  logic                 pix_valid,
	output logic                 pix_ready,
	input  pix_t                 pix,
	// result channel
	output logic                 res_valid,
	input  logic                 res_ready,
	output res_t                 res,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ENTRY_W-1:0]   cfg_data
);

	// configuration registers
	logic [COLOR_W-1:0] key_color_q;
	logic [COLOR_W-1:0] range_below_q;
	logic [COLOR_W-1:0] range_above_q;
	logic [COLOR_W-1:0] gray_color_q;
	logic [ENTRY_W-1:0] entry_q [ENTRY_SLOTS];

	logic [CFG_IDX_W-1:0] ent_off;
	logic [EIDX_W-1:0]    ent_idx;

	assign cfg_ready = 1'b1;
	assign ent_off   = cfg_index - REG_BLOCKED_0;
	assign ent_idx   = ent_off[EIDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_color_q   <= KEY_COLOR_RST;
			range_below_q <= RANGE_BELOW_RST;
			range_above_q <= RANGE_ABOVE_RST;
			gray_color_q  <= GRAY_COLOR_RST;
			for (int e = 0; e < ENTRY_SLOTS; e++) begin
				entry_q[e] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KEY_COLOR:   key_color_q   <= cfg_data[COLOR_W-1:0];
				REG_RANGE_BELOW: range_below_q <= cfg_data[COLOR_W-1:0];
				REG_RANGE_ABOVE: range_above_q <= cfg_data[COLOR_W-1:0];
				REG_GRAY_COLOR:  gray_color_q  <= cfg_data[COLOR_W-1:0];
				REG_BLOCKED_0, REG_BLOCKED_1, REG_BLOCKED_2, REG_BLOCKED_3: begin
					entry_q[ent_idx] <= cfg_data;
				end
				default: ;
			endcase
		end
	end

	// whole pipeline moves when the output register is free or being drained
	logic advance;
	assign advance   = !res_valid || res_ready;
	assign pix_ready = advance;

	// ---------------------------------------------------------------
	// stage 1: per-channel compares for the key window and every blocked range
	// ---------------------------------------------------------------
	logic [CHAN_W-1:0] orig_ch [3];
	logic [2:0]        key_ok_c;
	logic [BLOCKED_ENTRIES-1:0] hit_c;

	assign orig_ch[0] = pix.orig_b;
	assign orig_ch[1] = pix.orig_g;
	assign orig_ch[2] = pix.orig_r;

	// key lies in [pix - above, pix + below] with both ends clamped to 0..255;
	// the clamps never change the outcome when done in nine bits
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			key_ok_c[c] =
				({1'b0, key_color_q[CHAN_W*c +: CHAN_W]} <=
				 {1'b0, orig_ch[c]} + {1'b0, range_below_q[CHAN_W*c +: CHAN_W]}) &&
				({1'b0, key_color_q[CHAN_W*c +: CHAN_W]} +
				 {1'b0, range_above_q[CHAN_W*c +: CHAN_W]} >= {1'b0, orig_ch[c]});
		end
	end

	// a blocked range hits when valid and low <= pixel <= high on all channels
	always_comb begin
		for (int e = 0; e < BLOCKED_ENTRIES; e++) begin
			hit_c[e] = entry_q[e][ENT_VALID];
			for (int c = 0; c < 3; c++) begin
				if (orig_ch[c] < entry_q[e][ENT_LO_LSB + CHAN_W*c +: CHAN_W] ||
				    orig_ch[c] > entry_q[e][ENT_HI_LSB + CHAN_W*c +: CHAN_W]) begin
					hit_c[e] = 1'b0;
				end
			end
		end
	end

	logic                       valid_s1;
	pix_t                       pix_s1;
	logic [2:0]                 key_ok_s1;
	logic [BLOCKED_ENTRIES-1:0] hit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pix_s1    <= pix;
			key_ok_s1 <= key_ok_c;
			hit_s1    <= hit_c;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: first blocked match wins, key match beats everything
	// ---------------------------------------------------------------
	logic found_c;
	logic spill_c;
	src_t sel_c;

	always_comb begin
		found_c = 1'b0;
		spill_c = 1'b0;
		// walk from the back so the lowest index is the one left standing
		for (int e = BLOCKED_ENTRIES - 1; e >= 0; e--) begin
			if (hit_s1[e]) begin
				found_c = 1'b1;
				spill_c = entry_q[e][ENT_SPILL];
			end
		end
		if ((&key_ok_s1) || (found_c && !spill_c)) begin
			sel_c = SRC_FILT;
		end else if (found_c) begin
			sel_c = SRC_GRAY;
		end else begin
			sel_c = SRC_ORIG;
		end
	end

	logic valid_s2;
	pix_t pix_s2;
	src_t sel_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pix_s2 <= pix_s1;
			sel_s2 <= sel_c;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: output select into the result register
	// ---------------------------------------------------------------
	res_t res_c;

	always_comb begin
		res_c.chosen_source = sel_s2;
		case (sel_s2)
			SRC_FILT: begin
				res_c.out_b = pix_s2.filt_b;
				res_c.out_g = pix_s2.filt_g;
				res_c.out_r = pix_s2.filt_r;
			end
			SRC_GRAY: begin
				res_c.out_b = gray_color_q[0 +: CHAN_W];
				res_c.out_g = gray_color_q[CHAN_W +: CHAN_W];
				res_c.out_r = gray_color_q[2*CHAN_W +: CHAN_W];
			end
			default: begin
				res_c.out_b = pix_s2.orig_b;
				res_c.out_g = pix_s2.orig_g;
				res_c.out_r = pix_s2.orig_r;
			end
		endcase
	end

	logic valid_s3;
	res_t res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s3 <= res_c;
		end
	end

	assign res_valid = valid_s3;
	assign res       = res_s3;

`ifndef SYNTHESIS
	// a waiting result must freeze the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !pix_ready)
		else $error("pixel accepted while result stalled");

	// an accepted pixel transaction always lands in stage one
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> valid_s1)
		else $error("accepted pixel lost at stage one");

	// stage two contents reach the output register when the pipe moves
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s2 |=> res_valid)
		else $error("pixel lost between stage two and output");
`endif

endmodule
